FILE: hdl/i2cws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write/read sequencer package
// Shared types, command and status codes, and defaults for the sequencer.
// ----------------------------------------------------------------------------
package i2cws_pkg;

	// Defaults for the top-level parameters.
	localparam int TX_FIFO_DEPTH_DEF = 8;
	localparam int LENGTH_BITS_DEF   = 16;

	// The timeout register comes out of reset with this many milliseconds.
	localparam logic [15:0] TIMEOUT_RESET = 16'd10;

	// Event codes carried on the command field.
	localparam logic [3:0] CMD_START   = 4'd0;
	localparam logic [3:0] CMD_TXSPACE = 4'd1;
	localparam logic [3:0] CMD_TXDONE  = 4'd2;
	localparam logic [3:0] CMD_RXBYTE  = 4'd3;
	localparam logic [3:0] CMD_RXDONE  = 4'd4;
	localparam logic [3:0] CMD_NACK    = 4'd5;
	localparam logic [3:0] CMD_ARBLOST = 4'd6;
	localparam logic [3:0] CMD_TICK    = 4'd7;
	localparam logic [3:0] CMD_TAKE    = 4'd8;

	// Codes reported by a take event.
	localparam logic [1:0] TAKE_PENDING = 2'd0;
	localparam logic [1:0] TAKE_DONE    = 2'd1;
	localparam logic [1:0] TAKE_ERROR   = 2'd2;

	// Codes on the start_transfer field.
	localparam logic [1:0] XFER_NONE  = 2'd0;
	localparam logic [1:0] XFER_WRITE = 2'd1;
	localparam logic [1:0] XFER_READ  = 2'd2;

	// Encoded phase values as seen on the phase_now field.
	localparam logic [2:0] PCODE_IDLE = 3'd0;
	localparam logic [2:0] PCODE_TX   = 3'd1;
	localparam logic [2:0] PCODE_WAIT = 3'd2;
	localparam logic [2:0] PCODE_RX   = 3'd3;
	localparam logic [2:0] PCODE_DONE = 3'd4;
	localparam logic [2:0] PCODE_ERR  = 3'd5;

	// Transaction phase, one-hot.
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_TX   = 6'b000010,
		PH_WAIT = 6'b000100,
		PH_RX   = 6'b001000,
		PH_DONE = 6'b010000,
		PH_ERR  = 6'b100000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic        accepted;
		logic [2:0]  phase_now;
		logic [1:0]  take_status;
		logic [1:0]  start_transfer;
		logic [6:0]  bus_address_out;
		logic [15:0] transfer_length;
		logic [15:0] push_offset;
		logic [3:0]  push_count;
		logic        store_rx;
		logic [15:0] store_index;
		logic        abort_transfer;
	} result_t;

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		case (p)
			PH_IDLE: c = PCODE_IDLE;
			PH_TX:   c = PCODE_TX;
			PH_WAIT: c = PCODE_WAIT;
			PH_RX:   c = PCODE_RX;
			PH_DONE: c = PCODE_DONE;
			PH_ERR:  c = PCODE_ERR;
			default: c = PCODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/i2cws_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write/read sequencer event step
// Next-state and result logic for one event against the current context.
// ----------------------------------------------------------------------------
module i2cws_step #(
	parameter int TX_FIFO_DEPTH = i2cws_pkg::TX_FIFO_DEPTH_DEF,
	parameter int LENGTH_BITS   = i2cws_pkg::LENGTH_BITS_DEF
) (
	input  logic [3:0]             command,
	input  logic [6:0]             bus_address_in,
	input  logic [15:0]            write_bytes,
	input  logic [15:0]            read_bytes,
	input  logic [3:0]             tx_space,
	input  logic                   controller_idle,
	input  logic [31:0]            now_ms,
	input  logic [15:0]            timeout_ms,

	input  i2cws_pkg::phase_t      phase,
	input  logic [6:0]             target_address,
	input  logic [LENGTH_BITS-1:0] tx_total,
	input  logic [LENGTH_BITS-1:0] tx_done_count,
	input  logic [LENGTH_BITS-1:0] rx_total,
	input  logic [LENGTH_BITS-1:0] rx_done_count,
	input  logic [31:0]            deadline,

	output i2cws_pkg::phase_t      phase_nxt,
	output logic [6:0]             target_address_nxt,
	output logic [LENGTH_BITS-1:0] tx_total_nxt,
	output logic [LENGTH_BITS-1:0] tx_done_count_nxt,
	output logic [LENGTH_BITS-1:0] rx_total_nxt,
	output logic [LENGTH_BITS-1:0] rx_done_count_nxt,
	output logic [31:0]            deadline_nxt,
	output i2cws_pkg::result_t     result
);
	import i2cws_pkg::*;

	// The push count can never exceed the reported space, which is four bits wide.
	localparam int          CAP_INT = (TX_FIFO_DEPTH > 15) ? 15 : TX_FIFO_DEPTH;
	localparam logic [3:0]  FIFO_CAP = 4'(CAP_INT);

	logic [LENGTH_BITS-1:0] wlen;
	logic [LENGTH_BITS-1:0] rlen;
	logic [LENGTH_BITS-1:0] remaining;
	logic [3:0]             space_cap;
	logic [3:0]             push_n;
	logic                   active;
	logic [31:0]            since_deadline;

	assign wlen = LENGTH_BITS'(write_bytes);
	assign rlen = LENGTH_BITS'(read_bytes);

	assign active = (phase == PH_TX) || (phase == PH_WAIT) || (phase == PH_RX);

	// One shared push-size unit: a start pushes from the whole write length,
	// a space event from what is left.
	assign remaining = (command == CMD_START) ? wlen : (tx_total - tx_done_count);
	assign space_cap = (tx_space > FIFO_CAP) ? FIFO_CAP : tx_space;
	assign push_n    = (remaining < LENGTH_BITS'(space_cap)) ? 4'(remaining) : space_cap;

	// Wrapping compare: the deadline has passed when the difference is non-negative.
	assign since_deadline = now_ms - deadline;

	always_comb begin
		phase_nxt          = phase;
		target_address_nxt = target_address;
		tx_total_nxt       = tx_total;
		tx_done_count_nxt  = tx_done_count;
		rx_total_nxt       = rx_total;
		rx_done_count_nxt  = rx_done_count;
		deadline_nxt       = deadline;
		result             = '0;

		case (command)
			CMD_START: begin
				if ((phase == PH_IDLE) && (wlen != '0) && controller_idle) begin
					target_address_nxt     = bus_address_in;
					tx_total_nxt           = wlen;
					tx_done_count_nxt      = LENGTH_BITS'(push_n);
					rx_total_nxt           = rlen;
					rx_done_count_nxt      = '0;
					deadline_nxt           = now_ms + {16'd0, timeout_ms};
					phase_nxt              = PH_TX;
					result.accepted        = 1'b1;
					result.start_transfer  = XFER_WRITE;
					result.bus_address_out = bus_address_in;
					result.transfer_length = 16'(wlen);
					result.push_count      = push_n;
				end
			end
			CMD_TXSPACE: begin
				if ((phase == PH_TX) && (tx_done_count < tx_total)) begin
					result.push_offset = 16'(tx_done_count);
					result.push_count  = push_n;
					tx_done_count_nxt  = tx_done_count + LENGTH_BITS'(push_n);
				end
			end
			CMD_TXDONE: begin
				if (phase == PH_TX) begin
					phase_nxt = (rx_total == '0) ? PH_DONE : PH_WAIT;
				end
			end
			CMD_RXBYTE: begin
				if (active && (rx_done_count < rx_total)) begin
					result.store_rx    = 1'b1;
					result.store_index = 16'(rx_done_count);
					rx_done_count_nxt  = rx_done_count + LENGTH_BITS'(1);
				end
			end
			CMD_RXDONE: begin
				if (active) begin
					phase_nxt = (rx_done_count == rx_total) ? PH_DONE : PH_ERR;
				end
			end
			CMD_NACK, CMD_ARBLOST: begin
				if (active) begin
					phase_nxt             = PH_ERR;
					result.abort_transfer = 1'b1;
				end
			end
			CMD_TICK: begin
				if ((phase == PH_WAIT) && controller_idle) begin
					phase_nxt              = PH_RX;
					result.start_transfer  = XFER_READ;
					result.bus_address_out = target_address;
					result.transfer_length = 16'(rx_total);
				end else if (active && !since_deadline[31]) begin
					phase_nxt             = PH_ERR;
					result.abort_transfer = 1'b1;
				end
			end
			CMD_TAKE: begin
				if (phase == PH_DONE) begin
					result.take_status = TAKE_DONE;
					phase_nxt          = PH_IDLE;
				end else if (phase == PH_ERR) begin
					result.take_status = TAKE_ERROR;
					phase_nxt          = PH_IDLE;
				end
			end
			default: begin
			end
		endcase

		result.phase_now = phase_code(phase_nxt);
	end

endmodule

FILE: hdl/i2c_write_read_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write/read sequencer
// Tracks one write-then-optional-read transaction and tells the bus
// controller what to do for each event it reports.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   -------   ----------------------   ------------------------------------------
//   event     in_valid / in_stall      command, bus_address_in, write_bytes,
//                                      read_bytes, tx_space, rx_data,
//                                      controller_idle, now_ms
//   result    out_valid / out_stall    accepted ... abort_transfer
//   config    cfg_wr_en, cfg_wr_data   timeout_ms
//
// Every event produces exactly one result. An event waits in the input
// register, where the step logic evaluates it; when it leaves that register
// the context is updated and its result is captured in the output register.
// One event can be taken every cycle while out_stall is low.
// The output register and the input register together hold up to two
// events; in_stall rises only when both are full and out_stall is high.
// arst_n clears the context (phase idle, counts and deadline zero), empties
// both registers and sets the timeout to 10 ms.
// ----------------------------------------------------------------------------
module i2c_write_read_sequencer #(
	parameter int TX_FIFO_DEPTH = i2cws_pkg::TX_FIFO_DEPTH_DEF,
	parameter int LENGTH_BITS   = i2cws_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [6:0]  bus_address_in,
	input  logic [15:0] write_bytes,
	input  logic [15:0] read_bytes,
	input  logic [3:0]  tx_space,
	input  logic [7:0]  rx_data,
	input  logic        controller_idle,
	input  logic [31:0] now_ms,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [2:0]  phase_now,
	output logic [1:0]  take_status,
	output logic [1:0]  start_transfer,
	output logic [6:0]  bus_address_out,
	output logic [15:0] transfer_length,
	output logic [15:0] push_offset,
	output logic [3:0]  push_count,
	output logic        store_rx,
	output logic [15:0] store_index,
	output logic        abort_transfer
);
	import i2cws_pkg::*;

	// Timeout register.
	logic [15:0] timeout_q;

	// Input register.
	logic        valid_s1;
	logic [3:0]  command_s1;
	logic [6:0]  bus_address_s1;
	logic [15:0] write_bytes_s1;
	logic [15:0] read_bytes_s1;
	logic [3:0]  tx_space_s1;
	logic        controller_idle_s1;
	logic [31:0] now_ms_s1;

	// Transaction context.
	phase_t                 phase_q;
	logic [6:0]             target_address_q;
	logic [LENGTH_BITS-1:0] tx_total_q;
	logic [LENGTH_BITS-1:0] tx_done_count_q;
	logic [LENGTH_BITS-1:0] rx_total_q;
	logic [LENGTH_BITS-1:0] rx_done_count_q;
	logic [31:0]            deadline_q;

	// Next context and result from the step logic.
	phase_t                 phase_nxt;
	logic [6:0]             target_address_nxt;
	logic [LENGTH_BITS-1:0] tx_total_nxt;
	logic [LENGTH_BITS-1:0] tx_done_count_nxt;
	logic [LENGTH_BITS-1:0] rx_total_nxt;
	logic [LENGTH_BITS-1:0] rx_done_count_nxt;
	logic [31:0]            deadline_nxt;
	result_t                result_nxt;

	// Output register.
	logic    out_valid_q;
	result_t result_q;

	logic advance;
	logic in_take;

	// The event in the input register moves on whenever the output register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// The received byte is stored by the controller itself; only its index
	// is produced here, so rx_data is not kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1         <= command;
			bus_address_s1     <= bus_address_in;
			write_bytes_s1     <= write_bytes;
			read_bytes_s1      <= read_bytes;
			tx_space_s1        <= tx_space;
			controller_idle_s1 <= controller_idle;
			now_ms_s1          <= now_ms;
		end
	end

	i2cws_step #(
		.TX_FIFO_DEPTH (TX_FIFO_DEPTH),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_step (
		.command            (command_s1),
		.bus_address_in     (bus_address_s1),
		.write_bytes        (write_bytes_s1),
		.read_bytes         (read_bytes_s1),
		.tx_space           (tx_space_s1),
		.controller_idle    (controller_idle_s1),
		.now_ms             (now_ms_s1),
		.timeout_ms         (timeout_q),
		.phase              (phase_q),
		.target_address     (target_address_q),
		.tx_total           (tx_total_q),
		.tx_done_count      (tx_done_count_q),
		.rx_total           (rx_total_q),
		.rx_done_count      (rx_done_count_q),
		.deadline           (deadline_q),
		.phase_nxt          (phase_nxt),
		.target_address_nxt (target_address_nxt),
		.tx_total_nxt       (tx_total_nxt),
		.tx_done_count_nxt  (tx_done_count_nxt),
		.rx_total_nxt       (rx_total_nxt),
		.rx_done_count_nxt  (rx_done_count_nxt),
		.deadline_nxt       (deadline_nxt),
		.result             (result_nxt)
	);

	// The context changes exactly once per event, when its result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			target_address_q <= '0;
			tx_total_q       <= '0;
			tx_done_count_q  <= '0;
			rx_total_q       <= '0;
			rx_done_count_q  <= '0;
			deadline_q       <= '0;
		end else if (advance) begin
			phase_q          <= phase_nxt;
			target_address_q <= target_address_nxt;
			tx_total_q       <= tx_total_nxt;
			tx_done_count_q  <= tx_done_count_nxt;
			rx_total_q       <= rx_total_nxt;
			rx_done_count_q  <= rx_done_count_nxt;
			deadline_q       <= deadline_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = result_q.accepted;
	assign phase_now       = result_q.phase_now;
	assign take_status     = result_q.take_status;
	assign start_transfer  = result_q.start_transfer;
	assign bus_address_out = result_q.bus_address_out;
	assign transfer_length = result_q.transfer_length;
	assign push_offset     = result_q.push_offset;
	assign push_count      = result_q.push_count;
	assign store_rx        = result_q.store_rx;
	assign store_index     = result_q.store_index;
	assign abort_transfer  = result_q.abort_transfer;

	// While writing, the pushed count never runs past the write length.
	a_tx_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TX) |-> (tx_done_count_q <= tx_total_q))
		else $error("pushed byte count exceeds write length");

	// A stored byte advances the receive count by exactly one.
	a_rx_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result_nxt.store_rx) |=>
		(rx_done_count_q == $past(rx_done_count_q) + LENGTH_BITS'(1)))
		else $error("receive count did not advance on a stored byte");

	// Taking a finished result returns the context to idle.
	a_take_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (command_s1 == CMD_TAKE) && ((phase_q == PH_DONE) || (phase_q == PH_ERR)))
		|=> (phase_q == PH_IDLE))
		else $error("take did not return to idle");

	// Every event that leaves the input register shows up as a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost after event left input register");

	// The input side is held off only while an event waits in the input register.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room available");

endmodule
